>>> hw/rtl/blpd_pkg.sv
// ----------------------------------------------------------------------------
// blpd_pkg
// Shared types and codes for the bounded list with positional delete.
// ----------------------------------------------------------------------------
package blpd_pkg;

	localparam int unsigned DEPTH_DEF = 16;
	localparam int unsigned DATA_W    = 32;
	localparam int unsigned FUNC_W    = 3;
	localparam int unsigned INDEX_W   = 4;
	localparam int unsigned STATUS_W  = 2;

	localparam logic [FUNC_W-1:0] FN_INSERT_HEAD = 3'd0;
	localparam logic [FUNC_W-1:0] FN_REMOVE_HEAD = 3'd1;
	localparam logic [FUNC_W-1:0] FN_REMOVE_TAIL = 3'd2;
	localparam logic [FUNC_W-1:0] FN_REMOVE_AT   = 3'd3;
	localparam logic [FUNC_W-1:0] FN_READ_ALL    = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

	typedef struct packed {
		logic [FUNC_W-1:0]        func;
		logic signed [DATA_W-1:0] value_in;
		logic [INDEX_W-1:0]       index;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] value_out;
		logic [STATUS_W-1:0]      status;
		logic                     last;
	} rsp_t;

	typedef struct packed {
		logic cap;
		logic exec;
		logic stream;
	} ctl_cmd_t;

	typedef struct packed {
		logic bad_func;
		logic read_all;
		logic empty;
		logic ptr_last;
		logic rsp_free;
	} dp_stat_t;

endpackage

>>> hw/rtl/blpd_ctrl.sv
// ----------------------------------------------------------------------------
// blpd_ctrl
// Sequencer that takes one request word at a time and steps the datapath.
// ----------------------------------------------------------------------------
module blpd_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  blpd_pkg::dp_stat_t stat,
	output blpd_pkg::ctl_cmd_t cmd
);
	import blpd_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_EXEC   = 3'b010,
		S_STREAM = 3'b100
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		req_stall  = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.cap = 1'b1;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (stat.bad_func) begin
					state_d = S_IDLE;
				end else if (stat.read_all && !stat.empty) begin
					state_d = S_STREAM;
				end else if (stat.rsp_free) begin
					cmd.exec = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_STREAM: begin
				if (stat.rsp_free) begin
					cmd.stream = 1'b1;
					if (stat.ptr_last) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> hw/rtl/blpd_dpath.sv
// ----------------------------------------------------------------------------
// blpd_dpath
// Shifting storage cells, entry count, read pointer and result register.
// ----------------------------------------------------------------------------
module blpd_dpath #(
	parameter int unsigned DEPTH = blpd_pkg::DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  blpd_pkg::req_t     req,
	input  blpd_pkg::ctl_cmd_t cmd,
	output blpd_pkg::dp_stat_t stat,
	output blpd_pkg::rsp_t     rsp,
	output logic               rsp_valid,
	input  logic               rsp_stall
);
	import blpd_pkg::*;

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned XW = (CW > INDEX_W) ? CW : INDEX_W;

	req_t              req_q;
	logic [DATA_W-1:0] cells_q [DEPTH];
	logic [CW-1:0]     count_q;
	logic [AW-1:0]     ptr_q;
	rsp_t              rsp_q;
	logic              rsp_valid_q;

	logic              empty, full, in_range;
	logic              do_insert, do_remove;
	logic [AW-1:0]     pos, rd_addr;
	logic [DATA_W-1:0] rd_val;
	logic [STATUS_W-1:0] op_status;

	assign empty    = (count_q == '0);
	assign full     = (count_q == CW'(DEPTH));
	assign in_range = (XW'(req_q.index) < XW'(count_q));

	always_comb begin
		pos       = '0;
		op_status = ST_OK;
		do_insert = 1'b0;
		do_remove = 1'b0;
		unique case (req_q.func)
			FN_INSERT_HEAD: begin
				op_status = full ? ST_FULL : ST_OK;
				do_insert = !full;
			end
			FN_REMOVE_HEAD: begin
				op_status = empty ? ST_EMPTY : ST_OK;
				do_remove = !empty;
			end
			FN_REMOVE_TAIL: begin
				pos       = AW'(count_q - CW'(1));
				op_status = empty ? ST_EMPTY : ST_OK;
				do_remove = !empty;
			end
			FN_REMOVE_AT: begin
				pos = AW'(req_q.index);
				if (empty) begin
					op_status = ST_EMPTY;
				end else if (!in_range) begin
					op_status = ST_RANGE;
				end else begin
					do_remove = 1'b1;
				end
			end
			FN_READ_ALL: begin
				op_status = empty ? ST_EMPTY : ST_OK;
			end
			default: begin
				op_status = ST_OK;
			end
		endcase
	end

	assign rd_addr = cmd.stream ? ptr_q : pos;
	assign rd_val  = cells_q[rd_addr];

	assign stat.bad_func = (req_q.func != FN_INSERT_HEAD) && (req_q.func != FN_REMOVE_HEAD) &&
		(req_q.func != FN_REMOVE_TAIL) && (req_q.func != FN_REMOVE_AT) &&
		(req_q.func != FN_READ_ALL);
	assign stat.read_all = (req_q.func == FN_READ_ALL);
	assign stat.empty    = empty;
	assign stat.ptr_last = ((CW'(ptr_q) + CW'(1)) == count_q);
	assign stat.rsp_free = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			req_q <= req;
		end
		if (cmd.exec && do_insert) begin
			cells_q[0] <= req_q.value_in;
			for (int i = 1; i < DEPTH; i++) begin
				cells_q[i] <= cells_q[i-1];
			end
		end else if (cmd.exec && do_remove) begin
			for (int i = 0; i < DEPTH - 1; i++) begin
				if (AW'(i) >= pos) begin
					cells_q[i] <= cells_q[i+1];
				end
			end
		end
		if (cmd.exec) begin
			rsp_q.value_out <= do_remove ? rd_val : '0;
			rsp_q.status    <= op_status;
			rsp_q.last      <= 1'b1;
		end else if (cmd.stream) begin
			rsp_q.value_out <= rd_val;
			rsp_q.status    <= ST_OK;
			rsp_q.last      <= stat.ptr_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			ptr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.exec && do_insert) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.exec && do_remove) begin
				count_q <= count_q - CW'(1);
			end
			if (cmd.cap) begin
				ptr_q <= '0;
			end else if (cmd.stream) begin
				ptr_q <= ptr_q + AW'(1);
			end
			if (cmd.exec || cmd.stream) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

endmodule

>>> hw/rtl/bounded_list_with_positional_delete_core.sv
// ----------------------------------------------------------------------------
// bounded_list_with_positional_delete_core
// Ordered list of signed words with head insert and head, tail or indexed
// removal.
// ----------------------------------------------------------------------------
// The block holds up to DEPTH signed 32-bit entries in a row of registers
// that shift together, head at position 0. It takes one request word at a
// time: req_stall is high from the cycle after a word is accepted until the
// sequencer returns to idle. Insert and every removal give one result word;
// read all gives one result word per stored entry, with last on the final
// one, or one empty-status word on an empty list. Unused function codes
// give no result. Every result word passes through the single result
// register, and the sequencer waits while rsp_stall holds back the word
// in that register.
module bounded_list_with_positional_delete_core #(
	parameter int unsigned DEPTH = blpd_pkg::DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  blpd_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output blpd_pkg::rsp_t rsp
);
	import blpd_pkg::*;

	ctl_cmd_t cmd;
	dp_stat_t stat;

	blpd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	blpd_dpath #(
		.DEPTH (DEPTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.stat      (stat),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall)
	);

endmodule

>>> hw/rtl/blpd_checker.sv
// ----------------------------------------------------------------------------
// blpd_checker
// Port-level checks for the bounded list core, bound to its top level.
// ----------------------------------------------------------------------------
module blpd_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_stall,
	input blpd_pkg::req_t req,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input blpd_pkg::rsp_t rsp
);
	import blpd_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("Stalled result word changed or dropped.");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("Request accepted while another was in work.");

	a_error_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status != ST_OK) |-> rsp.last)
		else $error("Error result word not marked last.");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status != ST_OK) |-> (rsp.value_out == '0))
		else $error("Error result word carries a nonzero value.");

endmodule

bind bounded_list_with_positional_delete_core blpd_checker u_blpd_checker (.*);

>>> tb/tb_bounded_list_with_positional_delete_core.sv
// ----------------------------------------------------------------------------
// tb_bounded_list_with_positional_delete_core
// Self-checking testbench for the bounded list with positional delete.
// ----------------------------------------------------------------------------
// Requests are offered in bursts with random gaps between them. The response
// side stalls with a duty cycle that changes over time, and at one point it
// holds off for a long stretch so that the list core backs up its input. A
// queue-based copy of the list predicts every response word, and each
// accepted word is checked field by field against the oldest prediction.
// Directed tests cover the empty and full list, value extremes, indexes in
// and out of range and the unused function codes. Random traffic with a
// changing mix of inserts and removals follows.
// ----------------------------------------------------------------------------
module tb_bounded_list_with_positional_delete_core;

	timeunit 1ns;
	timeprecision 1ps;

	import blpd_pkg::*;

	localparam int CLK_PERIOD  = 10;
	localparam int QUIET_LIMIT = 3000;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE      = 20;

	localparam logic [FUNC_W-1:0] FN_SPARE_5 = 3'd5;
	localparam logic [FUNC_W-1:0] FN_SPARE_6 = 3'd6;
	localparam logic [FUNC_W-1:0] FN_SPARE_7 = 3'd7;

	localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	logic signed [DATA_W-1:0] list_model[$];
	rsp_t                     rsp_expected[$];

	int mismatches;
	int quiet_cycles;
	int hold_off_cycles;
	int burst_left;
	bit offering;

	bounded_list_with_positional_delete_core #(
		.DEPTH(DEPTH_DEF)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic void apply_request(input req_t w);
		rsp_t r;
		bit   answers;
		r         = '0;
		r.status  = ST_OK;
		r.last    = 1'b1;
		answers   = 1'b1;
		case (w.func)
			FN_INSERT_HEAD: begin
				if (list_model.size() >= DEPTH_DEF)
					r.status = ST_FULL;
				else
					list_model.push_front(w.value_in);
			end
			FN_REMOVE_HEAD: begin
				if (list_model.size() == 0)
					r.status = ST_EMPTY;
				else
					r.value_out = list_model.pop_front();
			end
			FN_REMOVE_TAIL: begin
				if (list_model.size() == 0)
					r.status = ST_EMPTY;
				else
					r.value_out = list_model.pop_back();
			end
			FN_REMOVE_AT: begin
				if (list_model.size() == 0) begin
					r.status = ST_EMPTY;
				end else if (w.index >= list_model.size()) begin
					r.status = ST_RANGE;
				end else begin
					r.value_out = list_model[w.index];
					list_model.delete(w.index);
				end
			end
			FN_READ_ALL: begin
				if (list_model.size() == 0) begin
					r.status = ST_EMPTY;
				end else begin
					answers = 1'b0;
					foreach (list_model[i]) begin
						r.value_out = list_model[i];
						r.last      = (i == list_model.size() - 1);
						rsp_expected.push_back(r);
					end
				end
			end
			default: answers = 1'b0;
		endcase
		if (answers)
			rsp_expected.push_back(r);
	endfunction

	function automatic void check_field(input string field, input logic [DATA_W-1:0] want,
			input logic [DATA_W-1:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %h, actual %h", $time, field, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (rsp_valid && !rsp_stall) begin
				if (rsp_expected.size() == 0) begin
					$display("%0t ns: unexpected word, expected none, actual %h", $time, rsp);
					mismatches++;
				end else begin
					want = rsp_expected.pop_front();
					check_field("value_out", want.value_out, rsp.value_out);
					check_field("status", DATA_W'(want.status), DATA_W'(rsp.status));
					check_field("last", DATA_W'(want.last), DATA_W'(rsp.last));
				end
			end
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t ns: no word moved for %0d cycles", $time, quiet_cycles);
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		int stall_pct;
		int phase_left;
		int n;
		rsp_stall  = 1'b0;
		stall_pct  = 0;
		phase_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off_cycles != 0) begin
				n               = hold_off_cycles;
				hold_off_cycles = 0;
				rsp_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			if (phase_left == 0) begin
				case ($urandom_range(0, 3))
					0: stall_pct = 0;
					1: stall_pct = 20;
					2: stall_pct = 50;
					default: stall_pct = 85;
				endcase
				phase_left = $urandom_range(10, 80);
			end
			phase_left--;
			rsp_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	task automatic send_word(input logic [FUNC_W-1:0] fn, input logic signed [DATA_W-1:0] value,
			input logic [INDEX_W-1:0] idx);
		req_t w;
		int   gap;
		w.func     = fn;
		w.value_in = value;
		w.index    = idx;
		req_valid <= 1'b1;
		req       <= w;
		offering   = 1'b1;
		forever begin
			@(posedge clk);
			if (!req_stall)
				break;
		end
		apply_request(w);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap        = $urandom_range(0, 8);
			if (gap != 0) begin
				req_valid <= 1'b0;
				offering   = 1'b0;
				repeat (gap) @(posedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	task automatic drain_results();
		if (offering) begin
			req_valid <= 1'b0;
			offering   = 1'b0;
		end
		while (rsp_expected.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic test_empty_list();
		send_word(FN_REMOVE_HEAD, $urandom, INDEX_W'($urandom));
		send_word(FN_REMOVE_TAIL, $urandom, INDEX_W'($urandom));
		send_word(FN_REMOVE_AT, $urandom, '0);
		send_word(FN_REMOVE_AT, $urandom, '1);
		send_word(FN_READ_ALL, $urandom, INDEX_W'($urandom));
		send_word(FN_SPARE_5, $urandom, INDEX_W'($urandom));
		send_word(FN_SPARE_6, $urandom, INDEX_W'($urandom));
		send_word(FN_SPARE_7, $urandom, INDEX_W'($urandom));
	endtask

	task automatic test_value_extremes();
		send_word(FN_INSERT_HEAD, VAL_MIN, '0);
		send_word(FN_INSERT_HEAD, VAL_MAX, '1);
		send_word(FN_INSERT_HEAD, '0, INDEX_W'($urandom));
		send_word(FN_INSERT_HEAD, '1, INDEX_W'($urandom));
		send_word(FN_INSERT_HEAD, 32'sh5555_aaaa, INDEX_W'($urandom));
		send_word(FN_READ_ALL, $urandom, INDEX_W'($urandom));
		send_word(FN_REMOVE_AT, $urandom, 4'd2);
		send_word(FN_REMOVE_AT, $urandom, 4'd9);
		send_word(FN_REMOVE_HEAD, $urandom, INDEX_W'($urandom));
		send_word(FN_REMOVE_TAIL, $urandom, INDEX_W'($urandom));
		send_word(FN_REMOVE_AT, $urandom, '0);
		send_word(FN_REMOVE_AT, $urandom, '0);
		send_word(FN_READ_ALL, $urandom, INDEX_W'($urandom));
	endtask

	task automatic test_full_list();
		while (list_model.size() < DEPTH_DEF)
			send_word(FN_INSERT_HEAD, $urandom, INDEX_W'($urandom));
		send_word(FN_INSERT_HEAD, $urandom, INDEX_W'($urandom));
		send_word(FN_READ_ALL, $urandom, INDEX_W'($urandom));
		send_word(FN_REMOVE_AT, $urandom, 4'd15);
		send_word(FN_REMOVE_AT, $urandom, 4'd8);
		send_word(FN_REMOVE_AT, $urandom, 4'd14);
		send_word(FN_REMOVE_AT, $urandom, 4'd0);
	endtask

	task automatic test_random_traffic(input int n_words, input int insert_pct);
		int                  pick;
		logic [FUNC_W-1:0]   fn;
		logic [INDEX_W-1:0]  idx;
		repeat (n_words) begin
			pick = $urandom_range(0, 99);
			if (pick < insert_pct) begin
				fn = FN_INSERT_HEAD;
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 2)
					fn = FN_SPARE_5;
				else if (pick < 4)
					fn = FN_SPARE_6;
				else if (pick < 6)
					fn = FN_SPARE_7;
				else if (pick < 18)
					fn = FN_READ_ALL;
				else if (pick < 50)
					fn = FN_REMOVE_AT;
				else if (pick < 75)
					fn = FN_REMOVE_HEAD;
				else
					fn = FN_REMOVE_TAIL;
			end
			if (list_model.size() != 0 && $urandom_range(0, 9) < 8)
				idx = INDEX_W'($urandom_range(0, list_model.size() - 1));
			else
				idx = INDEX_W'($urandom_range(0, (1 << INDEX_W) - 1));
			send_word(fn, $urandom, idx);
		end
	endtask

	task automatic test_backpressure();
		hold_off_cycles = HOLD_CYCLES;
		test_random_traffic(40, 60);
		drain_results();
	endtask

	initial begin
		clk             = 1'b0;
		arst_n          = 1'b0;
		req_valid       = 1'b0;
		req             = '0;
		mismatches      = 0;
		quiet_cycles    = 0;
		hold_off_cycles = 0;
		burst_left      = 0;
		offering        = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_list();
		test_value_extremes();
		drain_results();
		test_full_list();
		drain_results();
		test_backpressure();
		test_random_traffic(120, 70);
		drain_results();
		test_random_traffic(120, 25);
		test_random_traffic(200, 45);
		drain_results();

		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0 && rsp_expected.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

>>> sim.f
hw/rtl/blpd_pkg.sv
hw/rtl/blpd_ctrl.sv
hw/rtl/blpd_dpath.sv
hw/rtl/bounded_list_with_positional_delete_core.sv
hw/rtl/blpd_checker.sv
tb/tb_bounded_list_with_positional_delete_core.sv
